/* src/i2c_master_byte_engine_macros.svh */
// Assertion macros for the I2C byte engine.
// Included by the top level; no dependencies.
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define I2C_MBE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2c engine check failed");
// Next-cycle implication.
`define I2C_MBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2c engine check failed");
`else
`define I2C_MBE_ASSERT_NOW(label, clk, rst, ante, cons)
`define I2C_MBE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/i2c_mbe_pkg.sv */
// Shared types and constants for the I2C byte engine.
// No dependencies.
package i2c_mbe_pkg;

   localparam int DIVIDER_WIDTH_DEF = 16;
   localparam int HALF_PERIOD_W     = 16;
   localparam int ACK_TIMEOUT_W     = 8;
   localparam int CSR_DATA_W        = 16;
   localparam int CSR_ADDR_W        = 1;
   localparam int REQ_TDATA_W       = 16;
   localparam int RSP_TDATA_W       = 16;
   localparam int BITS_PER_BYTE     = 8;

   localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 16'd80;
   localparam logic [ACK_TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 8'd250;

   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_PERIOD = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACK_TIMEOUT = 1'b1;

   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_START     = 3'd1,
      CMD_STOP      = 3'd2,
      CMD_WRITE     = 3'd3,
      CMD_READ_ACK  = 3'd4,
      CMD_READ_NACK = 3'd5
   } cmd_type;

   typedef enum logic [14:0] {
      PH_IDLE    = 15'h0001,
      PH_ST_A    = 15'h0002,
      PH_ST_B    = 15'h0004,
      PH_SP_A    = 15'h0008,
      PH_SP_B    = 15'h0010,
      PH_SP_C    = 15'h0020,
      PH_WR_LO   = 15'h0040,
      PH_WR_HI   = 15'h0080,
      PH_AK_REL  = 15'h0100,
      PH_AK_HI   = 15'h0200,
      PH_AK_WAIT = 15'h0400,
      PH_RD_LO   = 15'h0800,
      PH_RD_HI   = 15'h1000,
      PH_MA_LO   = 15'h2000,
      PH_MA_HI   = 15'h4000
   } phase_type;

   // first member sits in the high bits, so the last field is tdata bit 0
   typedef struct packed {
      logic       sda_sample;
      logic [7:0] write_byte;
      logic [2:0] command;
   } item_type;

   typedef struct packed {
      logic       ack_error;
      logic [7:0] read_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_drive;
      logic       sda_level;
      logic       scl_level;
   } result_type;

endpackage

/* src/i2c_mbe_in_reg.sv */
// Input word register of the I2C byte engine.
// Depends on i2c_mbe_pkg.
module i2c_mbe_in_reg
   import i2c_mbe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   slot_free,
   output logic                   step,
   output item_type               item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   // a held word moves on whenever the result side has room
   assign step       = valid_ff & slot_free;
   assign req_tready = ~valid_ff | step;
   assign take       = req_tvalid & req_tready;

   assign valid_in = take | (valid_ff & ~step);
   assign item_in  = take ? item_type'(req_tdata[$bits(item_type)-1:0]) : item_ff;
   assign item     = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

/* src/i2c_mbe_core.sv */
// Bus phase sequencer, tick divider and config registers of the I2C engine.
// Depends on i2c_mbe_pkg.
module i2c_mbe_core
   import i2c_mbe_pkg::*;
#(
   parameter int DIVIDER_WIDTH = DIVIDER_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  step,
   input  item_type              item,
   output result_type            result
);

   logic [HALF_PERIOD_W-1:0] half_period_ff, half_period_in;
   logic [ACK_TIMEOUT_W-1:0] ack_timeout_ff, ack_timeout_in;

   phase_type                phase_ff, phase_in;
   logic [3:0]               bit_ff, bit_in;
   logic [7:0]               shift_ff, shift_in;
   logic [DIVIDER_WIDTH-1:0] tick_ff, tick_in;
   logic [7:0]               wait_ff, wait_in;
   logic                     scl_ff, scl_in;
   logic                     sda_ff, sda_in;
   logic                     drive_ff, drive_in;
   logic                     err_ff, err_in;
   logic [7:0]               hold_ff, hold_in;
   logic                     nack_ff, nack_in;
   logic                     done;

   logic [DIVIDER_WIDTH+HALF_PERIOD_W-1:0] hp_ext;
   logic [DIVIDER_WIDTH-1:0]               lim_raw, limit, tick_nx;
   logic                                   expire;
   logic [3:0]                             bit_nx;
   logic [7:0]                             wait_nx, rd_shift;

   // config
   always_comb begin
      half_period_in = half_period_ff;
      ack_timeout_in = ack_timeout_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_HALF_PERIOD: half_period_in = csr_wdata[HALF_PERIOD_W-1:0];
            CSR_ACK_TIMEOUT: ack_timeout_in = csr_wdata[ACK_TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // phase length: half_period cut or widened to the divider width, zero means one
   assign hp_ext  = {{DIVIDER_WIDTH{1'b0}}, half_period_ff};
   assign lim_raw = hp_ext[DIVIDER_WIDTH-1:0];
   assign limit   = (lim_raw == '0) ? DIVIDER_WIDTH'(1) : lim_raw;
   assign tick_nx = tick_ff + 1'b1;
   assign expire  = (tick_nx >= limit);

   assign bit_nx   = bit_ff + 4'd1;
   assign wait_nx  = wait_ff + 8'd1;
   assign rd_shift = {shift_ff[6:0], item.sda_sample};

   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      tick_in  = tick_ff;
      wait_in  = wait_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      drive_in = drive_ff;
      err_in   = err_ff;
      hold_in  = hold_ff;
      nack_in  = nack_ff;
      done     = 1'b0;
      if (step) begin
         if (phase_ff == PH_IDLE) begin
            unique case (cmd_type'(item.command))
               CMD_START: begin
                  drive_in = 1'b1; sda_in = 1'b1; scl_in = 1'b1;
                  phase_in = PH_ST_A; tick_in = '0;
               end
               CMD_STOP: begin
                  drive_in = 1'b1; scl_in = 1'b0; sda_in = 1'b0;
                  phase_in = PH_SP_A; tick_in = '0;
               end
               CMD_WRITE: begin
                  shift_in = item.write_byte; bit_in = '0; err_in = 1'b0;
                  drive_in = 1'b1; scl_in = 1'b0; sda_in = item.write_byte[7];
                  phase_in = PH_WR_LO; tick_in = '0;
               end
               CMD_READ_ACK, CMD_READ_NACK: begin
                  shift_in = '0; bit_in = '0;
                  nack_in  = (cmd_type'(item.command) == CMD_READ_NACK);
                  drive_in = 1'b0; scl_in = 1'b0; sda_in = 1'b1;
                  phase_in = PH_RD_LO; tick_in = '0;
               end
               default: ;
            endcase
         end else if (phase_ff == PH_AK_WAIT && !item.sda_sample) begin
            // slave ack ends the write at once
            scl_in = 1'b0; err_in = 1'b0;
            phase_in = PH_IDLE; tick_in = '0;
            done = 1'b1;
         end else if (!expire) begin
            tick_in = tick_nx;
         end else begin
            tick_in = '0;
            unique case (phase_ff)
               PH_ST_A: begin sda_in = 1'b0; phase_in = PH_ST_B; end
               PH_ST_B: begin scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1; end
               PH_SP_A: begin scl_in = 1'b1; phase_in = PH_SP_B; end
               PH_SP_B: begin sda_in = 1'b1; phase_in = PH_SP_C; end
               PH_SP_C: begin phase_in = PH_IDLE; done = 1'b1; end
               PH_WR_LO: begin scl_in = 1'b1; phase_in = PH_WR_HI; end
               PH_WR_HI: begin
                  scl_in = 1'b0;
                  bit_in = bit_nx;
                  if (bit_nx < 4'(BITS_PER_BYTE)) begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     sda_in   = shift_ff[6];
                     phase_in = PH_WR_LO;
                  end else begin
                     drive_in = 1'b0; sda_in = 1'b1;
                     phase_in = PH_AK_REL;
                  end
               end
               PH_AK_REL: begin scl_in = 1'b1; phase_in = PH_AK_HI; end
               PH_AK_HI: begin wait_in = '0; phase_in = PH_AK_WAIT; end
               PH_AK_WAIT: begin
                  wait_in = wait_nx;
                  if (wait_nx >= ack_timeout_ff || wait_nx == '0) begin
                     // no ack in time: flag it and send a stop
                     err_in = 1'b1;
                     drive_in = 1'b1; scl_in = 1'b0; sda_in = 1'b0;
                     phase_in = PH_SP_A;
                  end
               end
               PH_RD_LO: begin scl_in = 1'b1; phase_in = PH_RD_HI; end
               PH_RD_HI: begin
                  shift_in = rd_shift;
                  bit_in   = bit_nx;
                  scl_in   = 1'b0;
                  if (bit_nx < 4'(BITS_PER_BYTE)) begin
                     phase_in = PH_RD_LO;
                  end else begin
                     hold_in  = rd_shift;
                     drive_in = 1'b1; sda_in = nack_ff;
                     phase_in = PH_MA_LO;
                  end
               end
               PH_MA_LO: begin scl_in = 1'b1; phase_in = PH_MA_HI; end
               PH_MA_HI: begin scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1; end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_comb begin
      result.scl_level = scl_in;
      result.sda_level = sda_in;
      result.sda_drive = drive_in;
      result.busy_res  = (phase_in != PH_IDLE);
      result.done_res  = done;
      result.read_byte = hold_in;
      result.ack_error = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RST;
         ack_timeout_ff <= ACK_TIMEOUT_RST;
         phase_ff       <= PH_IDLE;
         bit_ff         <= '0;
         shift_ff       <= '0;
         tick_ff        <= '0;
         wait_ff        <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         drive_ff       <= 1'b1;
         err_ff         <= 1'b0;
         hold_ff        <= '0;
         nack_ff        <= 1'b0;
      end else begin
         half_period_ff <= half_period_in;
         ack_timeout_ff <= ack_timeout_in;
         phase_ff       <= phase_in;
         bit_ff         <= bit_in;
         shift_ff       <= shift_in;
         tick_ff        <= tick_in;
         wait_ff        <= wait_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         drive_ff       <= drive_in;
         err_ff         <= err_in;
         hold_ff        <= hold_in;
         nack_ff        <= nack_in;
      end
   end

endmodule

/* src/i2c_mbe_out_reg.sv */
// Result word register of the I2C byte engine.
// Depends on i2c_mbe_pkg.
module i2c_mbe_out_reg
   import i2c_mbe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  result_type             result,
   output logic                   slot_free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign slot_free = ~valid_ff | rsp_tready;
   assign valid_in  = load | (valid_ff & ~rsp_tready);
   assign res_in    = load ? result : res_ff;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - $bits(result_type)){1'b0}}, res_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

endmodule

/* src/i2c_master_byte_engine.sv */
// I2C byte engine: one input word per clock tick, one result word per input word.
// Latency: a req word is held in the input register, then its result in the result register,
// which drives rsp_tvalid; the rsp handshake for a word comes after its req handshake.
// Throughput one word per cycle unless rsp_tready stalls; phase sequencer advances once per word.
// Synchronous active-high reset: bus released high, SDA driven, idle, config to defaults.
// Depends on i2c_mbe_pkg, i2c_mbe_in_reg, i2c_mbe_core, i2c_mbe_out_reg and the macro header.
`include "i2c_master_byte_engine_macros.svh"

module i2c_master_byte_engine
   import i2c_mbe_pkg::*;
#(
   parameter int DIVIDER_WIDTH = DIVIDER_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: command[2:0], write_byte[10:3], sda_sample[11], zero[15:12]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
   //            read_byte[12:5], ack_error[13], zero[15:14]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic       step;
   logic       slot_free;
   item_type   item;
   result_type result;

   i2c_mbe_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .slot_free  (slot_free),
      .step       (step),
      .item       (item)
   );

   i2c_mbe_core #(
      .DIVIDER_WIDTH (DIVIDER_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .step      (step),
      .item      (item),
      .result    (result)
   );

   i2c_mbe_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // a new result only lands on a held word that is leaving this cycle
   `I2C_MBE_ASSERT_NOW(a_no_overwrite, clock, reset, step && rsp_tvalid, rsp_tready)
   // completion pulse never shows together with busy
   `I2C_MBE_ASSERT_NOW(a_done_not_busy, clock, reset, rsp_tvalid && rsp_tdata[4], !rsp_tdata[3])
   // released SDA always reads back as high
   `I2C_MBE_ASSERT_NOW(a_release_high, clock, reset, rsp_tvalid && !rsp_tdata[2], rsp_tdata[1])
   // an accepted word is waiting in the input register in the next cycle
   `I2C_MBE_ASSERT_NEXT(a_word_held, clock, reset, req_tvalid && req_tready, u_in_reg.valid_ff)

endmodule

/* bench/tb_i2c_master_byte_engine.sv */
// Self-checking bench for the I2C byte engine: drives one command/SDA word per bus tick,
// predicts every result word with a cycle model of the bus sequencer and compares fields.
// Depends on i2c_mbe_pkg and the i2c_master_byte_engine RTL.
module tb_i2c_master_byte_engine;
   import i2c_mbe_pkg::*;

   // command field values the engine treats as no-ops
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_PHASES = 4;
   localparam int WORDS_PER_PHASE = 100;

   // Bus sequencer model plus the queue of result words it owes the DUT.
   class bus_tick_board;
      phase_type                  ph;
      logic [3:0]                 nbits;
      logic [7:0]                 shreg;
      logic [DIVIDER_WIDTH_DEF-1:0] ticks;
      logic [7:0]                 waits;
      logic                       scl, sda, drv, err, nack;
      logic [7:0]                 rd_hold;
      logic [HALF_PERIOD_W-1:0]   half_period;
      logic [ACK_TIMEOUT_W-1:0]   ack_timeout;
      result_type                 due_levels[$];
      int                         faults, compared, acks, timeouts;
      int                         started[8];

      function new();
         half_period = HALF_PERIOD_RST;
         ack_timeout = ACK_TIMEOUT_RST;
         ph = PH_IDLE;
         nbits = '0;
         shreg = '0;
         ticks = '0;
         waits = '0;
         scl = 1'b1;
         sda = 1'b1;
         drv = 1'b1;
         err = 1'b0;
         nack = 1'b0;
         rd_hold = '0;
      endfunction

      function void enter(phase_type p);
         ph = p;
         ticks = '0;
      endfunction

      function void begin_stop();
         drv = 1'b1;
         scl = 1'b0;
         sda = 1'b0;
         enter(PH_SP_A);
      endfunction

      // end of a bus phase; returns 1 when the command completes
      function bit close_phase(logic s);
         case (ph)
            PH_ST_A: begin sda = 1'b0; enter(PH_ST_B); end
            PH_ST_B: begin scl = 1'b0; enter(PH_IDLE); return 1'b1; end
            PH_SP_A: begin scl = 1'b1; enter(PH_SP_B); end
            PH_SP_B: begin sda = 1'b1; enter(PH_SP_C); end
            PH_SP_C: begin enter(PH_IDLE); return 1'b1; end
            PH_WR_LO: begin scl = 1'b1; enter(PH_WR_HI); end
            PH_WR_HI: begin
               scl = 1'b0;
               nbits = nbits + 1'b1;
               if (nbits < BITS_PER_BYTE) begin
                  shreg = shreg << 1;
                  sda = shreg[7];
                  enter(PH_WR_LO);
               end else begin
                  drv = 1'b0;
                  sda = 1'b1;
                  enter(PH_AK_REL);
               end
            end
            PH_AK_REL: begin scl = 1'b1; enter(PH_AK_HI); end
            PH_AK_HI: begin waits = '0; enter(PH_AK_WAIT); end
            PH_AK_WAIT: begin
               waits = waits + 1'b1;
               // a wrapped counter also aborts; a zero window gives up after one phase
               if (waits >= ack_timeout || waits == 0) begin
                  err = 1'b1;
                  timeouts++;
                  begin_stop();
               end else begin
                  enter(PH_AK_WAIT);
               end
            end
            PH_RD_LO: begin scl = 1'b1; enter(PH_RD_HI); end
            PH_RD_HI: begin
               shreg = {shreg[6:0], s};
               nbits = nbits + 1'b1;
               scl = 1'b0;
               if (nbits < BITS_PER_BYTE) begin
                  enter(PH_RD_LO);
               end else begin
                  rd_hold = shreg;
                  drv = 1'b1;
                  sda = nack;
                  enter(PH_MA_LO);
               end
            end
            PH_MA_LO: begin scl = 1'b1; enter(PH_MA_HI); end
            PH_MA_HI: begin scl = 1'b0; enter(PH_IDLE); return 1'b1; end
            default: enter(PH_IDLE);
         endcase
         return 1'b0;
      endfunction

      function void take_tick(item_type it);
         logic [DIVIDER_WIDTH_DEF-1:0] lim, tc;
         bit         done;
         result_type r;
         done = 1'b0;
         if (ph == PH_IDLE) begin
            started[it.command]++;
            case (it.command)
               CMD_START: begin
                  drv = 1'b1;
                  sda = 1'b1;
                  scl = 1'b1;
                  enter(PH_ST_A);
               end
               CMD_STOP: begin_stop();
               CMD_WRITE: begin
                  shreg = it.write_byte;
                  nbits = '0;
                  err = 1'b0;
                  drv = 1'b1;
                  scl = 1'b0;
                  sda = it.write_byte[7];
                  enter(PH_WR_LO);
               end
               CMD_READ_ACK, CMD_READ_NACK: begin
                  shreg = '0;
                  nbits = '0;
                  nack = (it.command == CMD_READ_NACK);
                  drv = 1'b0;
                  scl = 1'b0;
                  sda = 1'b1;
                  enter(PH_RD_LO);
               end
               default: ;
            endcase
         end else if (ph == PH_AK_WAIT && it.sda_sample == 1'b0) begin
            // slave ack ends the write on the spot, SDA stays released
            scl = 1'b0;
            err = 1'b0;
            enter(PH_IDLE);
            done = 1'b1;
            acks++;
         end else begin
            lim = half_period[DIVIDER_WIDTH_DEF-1:0];
            tc = ticks + 1'b1;
            if (lim == 0) lim = DIVIDER_WIDTH_DEF'(1);
            if (tc >= lim) done = close_phase(it.sda_sample);
            else ticks = tc;
         end
         r.scl_level = scl;
         r.sda_level = sda;
         r.sda_drive = drv;
         r.busy_res = (ph != PH_IDLE);
         r.done_res = done;
         r.read_byte = rd_hold;
         r.ack_error = err;
         due_levels.push_back(r);
      endfunction

      function void match_levels(result_type got);
         result_type want;
         string      bad;
         if (due_levels.size() == 0) begin
            faults++;
            if (faults <= 10) $display("result word %h arrived with nothing expected", got);
            return;
         end
         want = due_levels.pop_front();
         compared++;
         bad = "";
         if (got.scl_level !== want.scl_level) bad = {bad, " scl_level"};
         if (got.sda_level !== want.sda_level) bad = {bad, " sda_level"};
         if (got.sda_drive !== want.sda_drive) bad = {bad, " sda_drive"};
         if (got.busy_res !== want.busy_res) bad = {bad, " busy_res"};
         if (got.done_res !== want.done_res) bad = {bad, " done_res"};
         if (got.read_byte !== want.read_byte) bad = {bad, " read_byte"};
         if (got.ack_error !== want.ack_error) bad = {bad, " ack_error"};
         if (bad != "") begin
            faults++;
            if (faults <= 10)
               $display("word %0d mismatch in%s: expected %h got %h", compared, bad, want, got);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = CSR_HALF_PERIOD;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   bus_tick_board sb;
   bit  steady;
   int  ack_pct, busy_noise, work_words, words_sent, settings, stall_cycles;

   i2c_master_byte_engine dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.match_levels(rsp_tdata[$bits(result_type)-1:0]);
      rsp_tready <= steady || ($urandom_range(0, 99) >= 28);
   end

   // no handshake on either side for this long means the engine or pipeline hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("no handshake for %0d cycles", STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_word(item_type it);
      if (!steady) begin
         while ($urandom_range(0, 99) < 28) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_TDATA_W'(it);
      do @(posedge clock); while (!req_tready);
      if (sb.ph != PH_IDLE || (it.command >= CMD_START && it.command <= CMD_READ_NACK))
         work_words++;
      words_sent++;
      sb.take_tick(it);
   endtask

   // one bus tick; SDA acts as the slave: ack chance during the ack window, data otherwise
   task automatic drive_tick(logic [2:0] cmd, logic [7:0] wb);
      item_type it;
      it.command = cmd;
      it.write_byte = wb;
      if (sb.ph == PH_AK_WAIT) it.sda_sample = ($urandom_range(1, 100) > ack_pct);
      else it.sda_sample = 1'($urandom_range(0, 1));
      push_word(it);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.due_levels.size() != 0);
   endtask

   // issue a command from idle and clock the bus until the engine is idle again
   task automatic issue(logic [2:0] cmd, logic [7:0] wb);
      drive_tick(cmd, wb);
      while (sb.ph != PH_IDLE) begin
         if ($urandom_range(0, 999) == 0) settle();
         if ($urandom_range(0, 99) < busy_noise)
            drive_tick(3'($urandom_range(CMD_NONE, CMD_SPARE_7)), 8'($urandom));
         else
            drive_tick(CMD_NONE, 8'($urandom));
      end
      repeat ($urandom_range(0, 2)) drive_tick(CMD_NONE, 8'($urandom));
   endtask

   task automatic set_config(logic [HALF_PERIOD_W-1:0] hp, logic [ACK_TIMEOUT_W-1:0] ato);
      sb.half_period = hp;
      sb.ack_timeout = ato;
      settings++;
      csr_we <= 1'b1;
      csr_addr <= CSR_HALF_PERIOD;
      csr_wdata <= CSR_DATA_W'(hp);
      @(posedge clock);
      csr_addr <= CSR_ACK_TIMEOUT;
      csr_wdata <= CSR_DATA_W'(ato);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // divider only; the ack window keeps whatever it holds
   task automatic set_half_period(logic [HALF_PERIOD_W-1:0] hp);
      sb.half_period = hp;
      settings++;
      csr_we <= 1'b1;
      csr_addr <= CSR_HALF_PERIOD;
      csr_wdata <= CSR_DATA_W'(hp);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int pick_ack();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 20;
         2: return 60;
         default: return 100;
      endcase
   endfunction

   function automatic logic [HALF_PERIOD_W-1:0] pick_half_period();
      case ($urandom_range(0, 5))
         0: return '0;
         1, 2: return HALF_PERIOD_W'(1);
         3: return HALF_PERIOD_W'(2);
         4: return HALF_PERIOD_W'(3);
         default: return HALF_PERIOD_W'($urandom_range(4, 6));
      endcase
   endfunction

   function automatic logic [ACK_TIMEOUT_W-1:0] pick_ack_timeout();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return ACK_TIMEOUT_W'(1);
         2: return ACK_TIMEOUT_W'($urandom_range(2, 6));
         3: return ACK_TIMEOUT_W'($urandom_range(21, 40));
         default: return ACK_TIMEOUT_W'($urandom_range(7, 20));
      endcase
   endfunction

   task automatic bus_frame();
      int n;
      if ($urandom_range(0, 4) == 0) begin
         // stray command: may break the frame or be a no-op code
         ack_pct = pick_ack();
         issue(3'($urandom_range(CMD_NONE, CMD_SPARE_7)), 8'($urandom));
         return;
      end
      issue(CMD_START, 8'($urandom));
      ack_pct = pick_ack();
      issue(CMD_WRITE, 8'($urandom));
      n = $urandom_range(1, 3);
      repeat (n) begin
         ack_pct = pick_ack();
         case ($urandom_range(0, 3))
            0, 1: issue(CMD_WRITE, 8'($urandom));
            2: issue(CMD_READ_ACK, 8'($urandom));
            default: issue(CMD_READ_NACK, 8'($urandom));
         endcase
      end
      if ($urandom_range(0, 2) == 0) begin
         // repeated start, address, single read
         issue(CMD_START, 8'($urandom));
         ack_pct = pick_ack();
         issue(CMD_WRITE, 8'($urandom));
         issue(CMD_READ_NACK, 8'($urandom));
      end
      issue(CMD_STOP, 8'($urandom));
   endtask

   initial begin
      int mark;
      sb = new();
      steady = 1'b0;
      busy_noise = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset timing: a start at the default divider, then a write with no ack
      // runs out the default window at one tick per phase
      ack_pct = 0;
      issue(CMD_START, 8'h00);
      settle();
      set_half_period(HALF_PERIOD_W'(1));
      issue(CMD_WRITE, 8'hFF);
      settle();

      set_config(HALF_PERIOD_W'(1), ACK_TIMEOUT_W'(3));
      issue(CMD_START, 8'h00);
      ack_pct = 100;
      issue(CMD_WRITE, 8'h00);
      ack_pct = 40;
      issue(CMD_WRITE, 8'hA5);
      issue(CMD_READ_ACK, 8'hFF);
      issue(CMD_READ_NACK, 8'h00);
      issue(CMD_NONE, 8'hFF);
      issue(CMD_SPARE_6, 8'h00);
      issue(CMD_SPARE_7, 8'hFF);
      // commands thrown at a busy engine must be dropped
      busy_noise = 100;
      ack_pct = 0;
      issue(CMD_WRITE, 8'h5A);
      busy_noise = 0;
      issue(CMD_START, 8'h00);
      issue(CMD_STOP, 8'h00);
      settle();

      // zero divider and zero ack window
      set_config('0, '0);
      issue(CMD_START, 8'h00);
      ack_pct = 0;
      issue(CMD_WRITE, 8'h80);
      ack_pct = 100;
      issue(CMD_WRITE, 8'h01);
      issue(CMD_READ_NACK, 8'h00);
      issue(CMD_STOP, 8'h00);
      settle();

      set_config(HALF_PERIOD_W'(2), ACK_TIMEOUT_W'(9));
      ack_pct = 0;
      issue(CMD_WRITE, 8'h7F);
      issue(CMD_STOP, 8'h00);
      settle();

      busy_noise = 15;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_config(pick_half_period(), pick_ack_timeout());
         steady = (p == 1);
         mark = work_words;
         while (work_words - mark < WORDS_PER_PHASE) bus_frame();
         settle();
      end
      steady = 1'b0;

      settle();
      repeat (16) @(posedge clock);
      if (sb.due_levels.size() != 0) begin
         sb.faults++;
         $display("%0d result words never arrived", sb.due_levels.size());
      end
      $display("%0d bus ticks (%0d doing work) over %0d timing settings, %0d words compared",
               words_sent, work_words, settings, sb.compared);
      $display("starts %0d, stops %0d, writes %0d (%0d acked, %0d timed out), reads %0d",
               sb.started[CMD_START], sb.started[CMD_STOP], sb.started[CMD_WRITE], sb.acks,
               sb.timeouts, sb.started[CMD_READ_ACK] + sb.started[CMD_READ_NACK]);
      if (sb.faults == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
